// File: rtl/core/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types and timing constants for the NEC IR frame transmitter core.
// ----------------------------------------------------------------------------
package necir_pkg;

    // Interval lengths in timer units
    localparam logic [13:0] T_HEADER = 14'd9000;
    localparam logic [13:0] T_LEAD   = 14'd4500;
    localparam logic [13:0] T_SHORT  = 14'd562;
    localparam logic [13:0] T_LONG   = 14'd1687;

    // Last bit index within one byte of the frame
    localparam logic [2:0]  BIT_LAST = 3'd7;

    // Event codes on the input channel
    localparam logic CMD_SEND   = 1'b0;
    localparam logic CMD_EXPIRE = 1'b1;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b000_0001,
        PH_LEAD  = 7'b000_0010,
        PH_ADDR  = 7'b000_0100,
        PH_ADDRI = 7'b000_1000,
        PH_CMD   = 7'b001_0000,
        PH_CMDI  = 7'b010_0000,
        PH_FINAL = 7'b100_0000
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] address_byte;
        logic [7:0] command_byte;
    } in_t;

    typedef struct packed {
        logic        carrier_on;
        logic        timer_running;
        logic        load_strobe;
        logic [13:0] load_value;
        logic        accepted;
    } out_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] frame_bits;
        logic [2:0]  bit_count;
        logic        mark_next;
        logic        carrier_level;
        logic        timer_enabled;
    } state_t;

endpackage

// File: rtl/core/necir_step.sv
// ----------------------------------------------------------------------------
// necir_step
// Next-state and result logic for one event of the frame sequencer.
// ----------------------------------------------------------------------------
module necir_step (
    input  necir_pkg::state_t cur,
    input  necir_pkg::in_t    item,
    input  logic [9:0]        comp,
    output necir_pkg::state_t nxt,
    output necir_pkg::out_t   res
);

    logic [13:0] mark_len;
    logic [13:0] one_len;
    logic [13:0] comp_ext;

    assign comp_ext = {4'd0, comp};
    // Mark saturates at zero; the long space can never go negative
    assign mark_len = (comp_ext >= necir_pkg::T_SHORT) ? 14'd0
                                                       : necir_pkg::T_SHORT - comp_ext;
    assign one_len  = necir_pkg::T_LONG - comp_ext;

    always_comb
    begin
        nxt          = cur;
        res.load_strobe = 1'b0;
        res.load_value  = 14'd0;
        res.accepted    = 1'b0;

        if (item.cmd == necir_pkg::CMD_SEND)
        begin
            if (cur.phase == necir_pkg::PH_IDLE)
            begin
                nxt.frame_bits    = {item.address_byte, ~item.address_byte,
                                     item.command_byte, ~item.command_byte};
                nxt.mark_next     = 1'b1;
                nxt.phase         = necir_pkg::PH_LEAD;
                nxt.carrier_level = 1'b1;
                nxt.timer_enabled = 1'b1;
                res.load_strobe   = 1'b1;
                res.load_value    = necir_pkg::T_HEADER;
                res.accepted      = 1'b1;
            end
        end
        else
        begin
            case (cur.phase)
                necir_pkg::PH_IDLE:
                begin
                    nxt.timer_enabled = 1'b0;
                    nxt.carrier_level = 1'b0;
                end
                necir_pkg::PH_LEAD:
                begin
                    nxt.carrier_level = 1'b0;
                    res.load_strobe   = 1'b1;
                    res.load_value    = necir_pkg::T_LEAD;
                    nxt.phase         = necir_pkg::PH_ADDR;
                    nxt.bit_count     = 3'd0;
                end
                necir_pkg::PH_ADDR, necir_pkg::PH_ADDRI,
                necir_pkg::PH_CMD,  necir_pkg::PH_CMDI:
                begin
                    res.load_strobe = 1'b1;
                    if (cur.mark_next)
                    begin
                        nxt.carrier_level = 1'b1;
                        res.load_value    = mark_len;
                    end
                    else
                    begin
                        nxt.carrier_level = 1'b0;
                        res.load_value    = cur.frame_bits[31] ? one_len
                                                               : necir_pkg::T_SHORT;
                        nxt.frame_bits    = {cur.frame_bits[30:0], 1'b0};
                        if (cur.bit_count == necir_pkg::BIT_LAST)
                        begin
                            nxt.bit_count = 3'd0;
                            case (cur.phase)
                                necir_pkg::PH_ADDR:  nxt.phase = necir_pkg::PH_ADDRI;
                                necir_pkg::PH_ADDRI: nxt.phase = necir_pkg::PH_CMD;
                                necir_pkg::PH_CMD:   nxt.phase = necir_pkg::PH_CMDI;
                                default:             nxt.phase = necir_pkg::PH_FINAL;
                            endcase
                        end
                        else
                        begin
                            nxt.bit_count = cur.bit_count + 3'd1;
                        end
                    end
                    nxt.mark_next = ~cur.mark_next;
                end
                necir_pkg::PH_FINAL:
                begin
                    nxt.carrier_level = 1'b1;
                    res.load_strobe   = 1'b1;
                    res.load_value    = necir_pkg::T_SHORT;
                    nxt.phase         = necir_pkg::PH_IDLE;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end

        res.carrier_on    = nxt.carrier_level;
        res.timer_running = nxt.timer_enabled;
    end

endmodule

// File: rtl/core/nec_ir_frame_transmitter_core.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter_core
// NEC IR frame sequencer driven by send requests and timer-expiry events.
// ----------------------------------------------------------------------------
// Results are registered and appear in the cycle after their input transfer.
// Throughput: one event per cycle unless out_ready stalls; sequencer state
//   and result come from one necir_step pass and are registered together.
// Reset (rst_n low, asynchronous): sequencer idle, carrier and timer off,
//   compensation 0, output register empty.
module nec_ir_frame_transmitter_core (
    input  logic            clk,
    input  logic            rst_n,
    // Event channel
    input  logic            in_valid,
    output logic            in_ready,
    input  necir_pkg::in_t  in_data,
    // Result channel
    output logic            out_valid,
    input  logic            out_ready,
    output necir_pkg::out_t out_data,
    // Compensation register write
    input  logic            cfg_we,
    input  logic [9:0]      cfg_data
);

    // Sequencer state, updated on every accepted event
    necir_pkg::state_t state_reg;
    necir_pkg::state_t state_next;
    necir_pkg::out_t   result;

    // Output register: holds the result until the downstream transfer
    necir_pkg::out_t   out_reg;
    logic              out_valid_reg;

    logic [9:0]        comp_reg;
    logic              in_xfer;

    // Ready whenever the output slot is empty or is being drained this cycle,
    // so events stream back to back while downstream keeps up.
    assign in_ready = ~out_valid_reg | out_ready;
    assign in_xfer  = in_valid & in_ready;

    necir_step u_step (
        .cur  (state_reg),
        .item (in_data),
        .comp (comp_reg),
        .nxt  (state_next),
        .res  (result)
    );

    // Compensation applies to marks and one-spaces; user must write it only while idle (unenforced)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg <= 10'd0;
        end
        else if (cfg_we)
        begin
            comp_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= necir_pkg::PH_IDLE;
            state_reg.frame_bits    <= 32'd0;
            state_reg.bit_count     <= 3'd0;
            state_reg.mark_next     <= 1'b1;
            state_reg.carrier_level <= 1'b0;
            state_reg.timer_enabled <= 1'b0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload register: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
